@@ rtl/scaled_glyph_text_rasterizer_unit_macros.svh @@
// assertion macros used by the rasterizer top level
`ifndef SCALED_GLYPH_TEXT_RASTERIZER_UNIT_MACROS_SVH
`define SCALED_GLYPH_TEXT_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SGR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sgr_pkg.sv @@
package sgr_pkg;

    // limits of the scale and screen registers
    localparam int unsigned MAX_DOT_SCALE  = 8;
    localparam int unsigned MAX_SCREEN_DIM = 4096;

    // register indexes on the configuration port
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DOT_SCALE     = 3'd2;
    localparam logic [2:0] REG_TEXT_COLOR    = 3'd3;
    localparam logic [2:0] REG_PIXEL_16BIT   = 3'd4;

    // glyph table geometry
    localparam int unsigned GLYPH_ROWS = 7;
    localparam int unsigned GLYPH_COLS = 5;
    localparam int unsigned GLYPH_DOTS = GLYPH_ROWS * GLYPH_COLS;

    // special glyph slots
    localparam logic [4:0] GLY_QUEST = 5'd26;
    localparam logic [4:0] GLY_DASH  = 5'd27;
    localparam logic [4:0] GLY_COLON = 5'd28;
    localparam logic [4:0] GLY_DOT   = 5'd29;
    localparam logic [4:0] GLY_SLASH = 5'd30;
    localparam logic [4:0] GLY_BLANK = 5'd31;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [3:0]  scale;
        logic [23:0] word;
    } t_cfg;

    // one character job passed from front to back
    typedef struct packed {
        logic [4:0]  glyph;
        logic [15:0] pen_col;
        logic [11:0] pen_row;
    } t_job;

    // one square, last field in the lowest bits
    typedef struct packed {
        logic [23:0] pixel_word;
        logic [3:0]  fill_height;
        logic [3:0]  fill_width;
        logic [11:0] fill_y;
        logic [11:0] fill_x;
    } t_fill;

    // map a character code to its glyph slot, lower case folded
    function automatic logic [4:0] glyph_index(input logic [7:0] code);
        logic [7:0] up;
        up = code;
        if (code >= 8'h61 && code <= 8'h7A) begin
            up = code - 8'h20;
        end
        if (up >= 8'h41 && up <= 8'h5A) begin
            return 5'(up - 8'h41);
        end
        case (up)
            8'h3F:   return GLY_QUEST;
            8'h2D:   return GLY_DASH;
            8'h3A:   return GLY_COLON;
            8'h2E:   return GLY_DOT;
            8'h2F:   return GLY_SLASH;
            default: return GLY_BLANK;
        endcase
    endfunction

    // font rows packed top row in the highest bits, msb of a row is leftmost
    function automatic logic [34:0] glyph_bits(input logic [4:0] g);
        case (g)
            5'd0:  return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            5'd1:  return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            5'd2:  return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            5'd3:  return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            5'd4:  return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            5'd5:  return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            5'd6:  return {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            5'd7:  return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            5'd8:  return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
            5'd9:  return {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
            5'd10: return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            5'd11: return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            5'd12: return {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            5'd13: return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            5'd14: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            5'd15: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            5'd16: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            5'd17: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            5'd18: return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            5'd19: return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            5'd20: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            5'd21: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04};
            5'd22: return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
            5'd23: return {5'h11, 5'h0A, 5'h0A, 5'h04, 5'h0A, 5'h0A, 5'h11};
            5'd24: return {5'h11, 5'h0A, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            5'd25: return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            5'd26: return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
            5'd27: return {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            5'd28: return {5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00};
            5'd29: return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
            5'd30: return {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
            default: return 35'd0;
        endcase
    endfunction

endpackage

@@ rtl/sgr_front.sv @@
module sgr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // char_code[7:0], restart[8], start_x[20:9], start_y[32:21], zero fill
    input  logic [39:0]          i_s_tdata,
    input  sgr_pkg::t_cfg        i_cfg,
    input  logic                 i_full,
    output logic                 o_push,
    output sgr_pkg::t_job        o_job
);
    import sgr_pkg::*;

    logic [15:0] r_pen_col;
    logic [11:0] r_pen_row;
    logic [15:0] n_pen_col;
    logic [11:0] n_pen_row;
    logic [15:0] base_col;
    logic [5:0]  advance;
    logic [16:0] col_sum;
    logic        restart;

    // accept while the queue has room
    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign restart    = i_s_tdata[8];

    // pen reload and glyph classification
    always_comb begin
        base_col  = restart ? {4'd0, i_s_tdata[20:9]} : r_pen_col;
        n_pen_row = restart ? i_s_tdata[32:21] : r_pen_row;
        o_job.glyph   = glyph_index(i_s_tdata[7:0]);
        o_job.pen_col = base_col;
        o_job.pen_row = n_pen_row;
    end

    // pen advance of six dots, saturating
    always_comb begin
        advance   = {i_cfg.scale, 2'b00} + {1'b0, i_cfg.scale, 1'b0};
        col_sum   = {1'b0, base_col} + {11'd0, advance};
        n_pen_col = col_sum[16] ? 16'hFFFF : col_sum[15:0];
    end

    // pen state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_col <= '0;
            r_pen_row <= '0;
        end else if (o_push) begin
            r_pen_col <= n_pen_col;
            r_pen_row <= n_pen_row;
        end
    end

endmodule

@@ rtl/sgr_queue.sv @@
module sgr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sgr_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output sgr_pkg::t_job o_job
);
    import sgr_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/sgr_back.sv @@
module sgr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sgr_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  sgr_pkg::t_job  i_q_job,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output sgr_pkg::t_fill o_fill,
    output logic           o_last
);
    import sgr_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} t_state;

    t_state      r_state;
    logic [34:0] r_bits;
    logic [2:0]  r_row;
    logic [2:0]  r_col;
    logic [15:0] r_pen_col;
    logic [16:0] r_xcur;
    logic [12:0] r_ycur;
    t_fill       r_hold;
    logic        r_hold_valid;
    t_fill       r_out;
    logic        r_out_last;
    logic        r_out_valid;

    logic        x_in;
    logic        y_in;
    logic        vis;
    logic [17:0] x_end;
    logic [13:0] y_end;
    logic [16:0] x_left;
    logic [12:0] y_left;
    t_fill       n_cand;
    logic        out_free;
    logic        out_load;
    logic        out_last;
    logic        step;

    assign o_valid  = r_out_valid;
    assign o_fill   = r_out;
    assign o_last   = r_out_last;
    assign o_q_pop  = (r_state == ST_IDLE) && i_q_valid;
    assign out_free = !r_out_valid || i_ready;

    // clip the current dot square against the screen
    always_comb begin
        x_in   = r_xcur < {4'd0, i_cfg.width};
        y_in   = r_ycur < i_cfg.height;
        vis    = r_bits[34] && x_in && y_in;
        x_end  = {1'b0, r_xcur} + {14'd0, i_cfg.scale};
        y_end  = {1'b0, r_ycur} + {10'd0, i_cfg.scale};
        x_left = {4'd0, i_cfg.width} - r_xcur;
        y_left = i_cfg.height - r_ycur;
        n_cand.fill_x      = r_xcur[11:0];
        n_cand.fill_y      = r_ycur[11:0];
        n_cand.fill_width  = (x_end > {5'd0, i_cfg.width}) ? x_left[3:0] : i_cfg.scale;
        n_cand.fill_height = (y_end > {1'b0, i_cfg.height}) ? y_left[3:0] : i_cfg.scale;
        n_cand.pixel_word  = i_cfg.word;
    end

    // hold one square back so the final one can be marked
    always_comb begin
        out_load = 1'b0;
        out_last = 1'b0;
        step     = 1'b0;
        unique case (r_state)
            ST_SCAN: begin
                step     = !(vis && r_hold_valid && !out_free);
                out_load = vis && r_hold_valid && out_free;
            end
            ST_FLUSH: begin
                out_load = r_hold_valid && out_free;
                out_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer, dot scan and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out       <= r_hold;
                r_out_last  <= out_last;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_bits    <= glyph_bits(i_q_job.glyph);
                        r_row     <= 3'd0;
                        r_col     <= 3'd0;
                        r_pen_col <= i_q_job.pen_col;
                        r_xcur    <= {1'b0, i_q_job.pen_col};
                        r_ycur    <= {1'b0, i_q_job.pen_row};
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (step) begin
                        if (vis) begin
                            r_hold       <= n_cand;
                            r_hold_valid <= 1'b1;
                        end
                        r_bits <= {r_bits[33:0], 1'b0};
                        if (r_col == 3'(GLYPH_COLS - 1)) begin
                            r_col  <= 3'd0;
                            r_row  <= r_row + 3'd1;
                            r_xcur <= {1'b0, r_pen_col};
                            r_ycur <= r_ycur + {9'd0, i_cfg.scale};
                            if (r_row == 3'(GLYPH_ROWS - 1)) begin
                                r_state <= ST_FLUSH;
                            end
                        end else begin
                            r_col  <= r_col + 3'd1;
                            r_xcur <= r_xcur + {13'd0, i_cfg.scale};
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_hold_valid) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_hold_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/scaled_glyph_text_rasterizer_unit.sv @@
// channel   dir  handshake                 payload
// s_axis    in   i_s_tvalid / o_s_tready   i_s_tdata  char, restart, start x/y
// m_axis    out  o_m_tvalid / i_m_tready   o_m_tdata  square, o_m_tlast last_dot
// cfg       in   i_cfg_wen                 i_cfg_addr, i_cfg_wdata
//
// each character scans its 35 font dots one per cycle in the back sequencer
// while the scan is not stalled, then passes the flush state, which marks the
// final square, and the idle state, which fetches the next job.
// the front takes characters into a two-entry job queue while the back scans.
// reset is synchronous, active low; config returns to 640x480, scale 1, white.
// a stalled output only stops the scan when a second visible square is ready.
module scaled_glyph_text_rasterizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // char_code[7:0], restart[8], start_x[20:9], start_y[32:21], zero fill
    input  logic [39:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // fill_x[11:0], fill_y[23:12], fill_width[27:24], fill_height[31:28],
    // pixel_word[55:32]
    output logic [55:0] o_m_tdata,
    output logic        o_m_tlast,
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata
);
    import sgr_pkg::*;
    `include "scaled_glyph_text_rasterizer_unit_macros.svh"

    logic [12:0] r_screen_width;
    logic [12:0] r_screen_height;
    logic [3:0]  r_dot_scale;
    logic [23:0] r_text_color;
    logic        r_pixel_16bit;

    t_cfg  cfg;
    t_job  front_job;
    t_job  q_job;
    t_fill fill;
    logic  push;
    logic  full;
    logic  q_valid;
    logic  q_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= 13'd640;
            r_screen_height <= 13'd480;
            r_dot_scale     <= 4'd1;
            r_text_color    <= 24'hFFFFFF;
            r_pixel_16bit   <= 1'b0;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_wdata[12:0];
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_wdata[12:0];
                REG_DOT_SCALE:     r_dot_scale     <= i_cfg_wdata[3:0];
                REG_TEXT_COLOR:    r_text_color    <= i_cfg_wdata;
                REG_PIXEL_16BIT:   r_pixel_16bit   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // clamp limits and build the colour word
    always_comb begin
        cfg.width  = (r_screen_width > 13'(MAX_SCREEN_DIM)) ?
                     13'(MAX_SCREEN_DIM) : r_screen_width;
        cfg.height = (r_screen_height > 13'(MAX_SCREEN_DIM)) ?
                     13'(MAX_SCREEN_DIM) : r_screen_height;
        if (r_dot_scale == 4'd0) begin
            cfg.scale = 4'd1;
        end else if (r_dot_scale > 4'(MAX_DOT_SCALE)) begin
            cfg.scale = 4'(MAX_DOT_SCALE);
        end else begin
            cfg.scale = r_dot_scale;
        end
        cfg.word = r_pixel_16bit ?
                   {8'd0, r_text_color[23:19], r_text_color[15:10], r_text_color[7:3]} :
                   r_text_color;
    end

    sgr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_cfg      (cfg),
        .i_full     (full),
        .o_push     (push),
        .o_job      (front_job)
    );

    sgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_job)
    );

    sgr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_fill    (fill),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = fill;

    // squares are never empty and never wider than one dot
    `SGR_ASSERT_NOW(a_fill_size, i_clk, i_rst_n, o_m_tvalid, (fill.fill_width != 4'd0) && (fill.fill_height != 4'd0) && (fill.fill_width <= cfg.scale) && (fill.fill_height <= cfg.scale), "square size out of range")
    // squares start on screen
    `SGR_ASSERT_NOW(a_fill_onscreen, i_clk, i_rst_n, o_m_tvalid, ({1'b0, fill.fill_x} < cfg.width) && ({1'b0, fill.fill_y} < cfg.height), "square starts off screen")
    // a full queue refuses the next character
    `SGR_ASSERT_NEXT(a_queue_full, i_clk, i_rst_n, full && !q_pop, !o_s_tready, "queue accepted while full")

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sgr_pkg::*;

    localparam int unsigned SETTLE_CYCLES   = 200;
    localparam int unsigned WATCHDOG_LIMIT  = 3000;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned ITEMS_PER_PHASE = 22;
    // characters at scale 8 that carry the pen from 4095 past the right border
    localparam int unsigned PEN_RUN_CHARS   = 8;

    // register indexes that decode to nothing
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // punctuation the font knows, first entry at index 0
    localparam logic [0:4][7:0] PUNCT = "?-:./";

    // 5x7 font, one entry per glyph slot, top row in the highest bits
    localparam logic [0:31][34:0] FONT_DOTS = {
        {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
        {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
        {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
        {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
        {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
        {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
        {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C},
        {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
        {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
        {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
        {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
        {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
        {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
        {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
        {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        {5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04},
        {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
        {5'h11, 5'h0A, 5'h0A, 5'h04, 5'h0A, 5'h0A, 5'h11},
        {5'h11, 5'h0A, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
        {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
        {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04},
        {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        {5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00},
        {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06},
        {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10},
        35'd0
    };

    // one character item, last field in the lowest bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [11:0] start_y;
        logic [11:0] start_x;
        logic        restart;
        logic [7:0]  char_code;
    } char_item_t;

    // one expected square
    typedef struct packed {
        logic [11:0] fill_x;
        logic [11:0] fill_y;
        logic [3:0]  fill_width;
        logic [3:0]  fill_height;
        logic [23:0] pixel_word;
        logic        last_dot;
    } square_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    // char_code[7:0], restart[8], start_x[20:9], start_y[32:21], zero fill
    logic [39:0] i_s_tdata   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    // fill_x[11:0], fill_y[23:12], fill_width[27:24], fill_height[31:28],
    // pixel_word[55:32]
    logic [55:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_wen   = 1'b0;
    logic [2:0]  i_cfg_addr  = REG_SCREEN_WIDTH;
    logic [23:0] i_cfg_wdata = '0;

    // register mirror, reset values
    logic [12:0] cfg_width  = 13'd640;
    logic [12:0] cfg_height = 13'd480;
    logic [3:0]  cfg_scale  = 4'd1;
    logic [23:0] cfg_color  = 24'hFFFFFF;
    logic        cfg_16bit  = 1'b0;

    // pen mirror
    logic [15:0] pen_col = '0;
    logic [11:0] pen_row = '0;

    char_item_t  pending_chars[$];
    square_t     expected_squares[$];
    char_item_t  src_item = '0;
    square_t     want;
    t_fill       seen_fill;
    int unsigned src_gap      = 0;
    int unsigned sink_gap     = 0;
    int unsigned quiet_cycles = 0;
    int unsigned fail_count   = 0;
    bit          idling_on    = 1'b1;

    scaled_glyph_text_rasterizer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // character code to font slot, lower case folded
    function automatic logic [4:0] font_slot(input logic [7:0] code);
        logic [7:0] up;
        up = (code >= "a" && code <= "z") ? code - ("a" - "A") : code;
        if (up >= "A" && up <= "Z") begin
            return 5'(up - "A");
        end
        case (up)
            "?":     return GLY_QUEST;
            "-":     return GLY_DASH;
            ":":     return GLY_COLON;
            ".":     return GLY_DOT;
            "/":     return GLY_SLASH;
            default: return GLY_BLANK;
        endcase
    endfunction

    // squares one character draws, pen update included
    task automatic rasterize_char(input char_item_t it);
        int unsigned scale, w, h, x0, y0, x1, y1, pen_next;
        logic [23:0] word;
        logic [34:0] dots;
        square_t     sq, held;
        bit          have_held;
        have_held = 1'b0;
        held = '0;
        scale = (cfg_scale == 0) ? 1 : cfg_scale;
        if (scale > MAX_DOT_SCALE) begin
            scale = MAX_DOT_SCALE;
        end
        w = (cfg_width > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : cfg_width;
        h = (cfg_height > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : cfg_height;
        if (it.restart) begin
            pen_col = 16'(it.start_x);
            pen_row = it.start_y;
        end
        // rgb565 takes the top 5/6/5 bits of each channel
        word = cfg_16bit ? {8'h00, cfg_color[23:19], cfg_color[15:10], cfg_color[7:3]}
                         : cfg_color;
        dots = FONT_DOTS[font_slot(it.char_code)];
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            for (int c = 0; c < GLYPH_COLS; c++) begin
                if (dots[6'(GLYPH_DOTS - 1 - (r * GLYPH_COLS + c))]) begin
                    x0 = pen_col + c * scale;
                    y0 = pen_row + r * scale;
                    if (x0 < w && y0 < h) begin
                        x1 = (x0 + scale > w) ? w : x0 + scale;
                        y1 = (y0 + scale > h) ? h : y0 + scale;
                        sq.fill_x      = 12'(x0);
                        sq.fill_y      = 12'(y0);
                        sq.fill_width  = 4'(x1 - x0);
                        sq.fill_height = 4'(y1 - y0);
                        sq.pixel_word  = word;
                        sq.last_dot    = 1'b0;
                        // hold one back so the final square can be marked
                        if (have_held) begin
                            expected_squares.push_back(held);
                        end
                        held = sq;
                        have_held = 1'b1;
                    end
                end
            end
        end
        if (have_held) begin
            held.last_dot = 1'b1;
            expected_squares.push_back(held);
        end
        // pen advance, saturating
        pen_next = pen_col + (GLYPH_COLS + 1) * scale;
        pen_col = (pen_next > 16'hFFFF) ? 16'hFFFF : 16'(pen_next);
    endtask

    task automatic check_field(input string name, input logic [23:0] exp_v,
                               input logic [23:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic queue_char(input logic [7:0] code, input bit restart,
                              input int unsigned x, input int unsigned y);
        char_item_t it;
        it = '0;
        it.char_code = code;
        it.restart   = restart;
        it.start_x   = 12'(x);
        it.start_y   = 12'(y);
        pending_chars.push_back(it);
    endtask

    // random character, pen mostly placed where something is visible
    task automatic queue_random_char();
        char_item_t  it;
        int unsigned w, h;
        it = '0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: it.char_code = "A" + 8'($urandom_range(0, 25));
            4, 5:       it.char_code = "a" + 8'($urandom_range(0, 25));
            6, 7:       it.char_code = PUNCT[3'($urandom_range(0, 4))];
            default:    it.char_code = 8'($urandom_range(0, 255));
        endcase
        it.restart = ($urandom_range(0, 2) == 0);
        w = (cfg_width > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : cfg_width;
        h = (cfg_height > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : cfg_height;
        case ($urandom_range(0, 2))
            0: begin
                it.start_x = 12'($urandom);
                it.start_y = 12'($urandom);
            end
            1: begin
                it.start_x = 12'($urandom_range(0, (w > 0) ? w - 1 : 0));
                it.start_y = 12'($urandom_range(0, (h > 0) ? h - 1 : 0));
            end
            default: begin
                // near the right and bottom borders for partial clipping
                it.start_x = 12'((w > 48) ? w - $urandom_range(1, 48)
                                          : $urandom_range(0, 48));
                it.start_y = 12'((h > 48) ? h - $urandom_range(1, 48)
                                          : $urandom_range(0, 48));
            end
        endcase
        pending_chars.push_back(it);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [23:0] value);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        case (addr)
            REG_SCREEN_WIDTH:  cfg_width  = value[12:0];
            REG_SCREEN_HEIGHT: cfg_height = value[12:0];
            REG_DOT_SCALE:     cfg_scale  = value[3:0];
            REG_TEXT_COLOR:    cfg_color  = value;
            REG_PIXEL_16BIT:   cfg_16bit  = value[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    // all registers, junk in the unused upper bits, plus an unknown index
    task automatic apply_settings(input int unsigned w, input int unsigned h,
                                  input int unsigned s, input logic [23:0] color,
                                  input bit px16);
        write_reg(REG_SCREEN_WIDTH, {11'($urandom), 13'(w)});
        write_reg(REG_SCREEN_HEIGHT, {11'($urandom), 13'(h)});
        write_reg(REG_DOT_SCALE, {20'($urandom), 4'(s)});
        write_reg(REG_TEXT_COLOR, color);
        write_reg(REG_PIXEL_16BIT, {23'($urandom), px16});
        write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 24'($urandom));
    endtask

    // wait until nothing is queued, in flight or expected, then let it settle
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_chars.size() != 0 || i_s_tvalid || expected_squares.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // character driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                rasterize_char(src_item);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 4) == 0) begin
                    src_gap = $urandom_range(0, 10);
                    i_s_tvalid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    src_item = pending_chars.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= src_item;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // square monitor, output stalls and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_gap = 0;
            quiet_cycles = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                seen_fill = o_m_tdata;
                if (expected_squares.size() == 0) begin
                    $error("square with no expectation: x %0d, y %0d",
                           seen_fill.fill_x, seen_fill.fill_y);
                    fail_count++;
                end else begin
                    want = expected_squares.pop_front();
                    check_field("fill_x", 24'(want.fill_x), 24'(seen_fill.fill_x));
                    check_field("fill_y", 24'(want.fill_y), 24'(seen_fill.fill_y));
                    check_field("fill_width", 24'(want.fill_width),
                                24'(seen_fill.fill_width));
                    check_field("fill_height", 24'(want.fill_height),
                                24'(seen_fill.fill_height));
                    check_field("pixel_word", want.pixel_word, seen_fill.pixel_word);
                    check_field("last_dot", 24'(want.last_dot), 24'(o_m_tlast));
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_m_tready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 10);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every glyph kind at the reset settings
        queue_char("A", 1'b1, 0, 0);
        queue_char("b", 1'b0, 0, 0);
        queue_char("?", 1'b0, 0, 0);
        queue_char("-", 1'b0, 0, 0);
        queue_char(":", 1'b0, 0, 0);
        queue_char(".", 1'b0, 0, 0);
        queue_char("/", 1'b0, 0, 0);
        queue_char(" ", 1'b0, 0, 0);
        queue_char(8'hFF, 1'b0, 0, 0);
        queue_char(8'h00, 1'b0, 0, 0);
        queue_char("z", 1'b0, 0, 0);
        // partly off the right and bottom, then wholly off screen
        queue_char("M", 1'b1, 636, 476);
        queue_char("W", 1'b1, 4095, 4095);
        wait_idle();

        // zero height clips everything, oversized width, zero scale
        apply_settings(8191, 0, 0, 24'h123456, 1'b0);
        queue_char("H", 1'b1, 10, 10);
        queue_char("X", 1'b0, 0, 0);
        wait_idle();

        // oversized scale and screen, rgb565, squares clipped to a partial size
        apply_settings(8191, 8191, 15, 24'hFFFFFF, 1'b1);
        queue_char("E", 1'b1, 4090, 4090);
        queue_char("O", 1'b1, 0, 0);
        queue_char("K", 1'b0, 0, 0);
        wait_idle();

        // zero width clips everything
        apply_settings(0, 4096, 3, 24'h000000, 1'b1);
        queue_char("I", 1'b1, 0, 0);
        wait_idle();

        // run without restart carries the pen beyond the right border
        apply_settings(4096, 4096, 8, 24'($urandom), 1'b0);
        queue_char("A", 1'b1, 4095, 0);
        repeat (PEN_RUN_CHARS) queue_char("A", 1'b0, 0, 0);
        queue_char("V", 1'b1, 0, 0);
        wait_idle();

        // random phases over several settings, no idling in the last one
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: apply_settings(640, 480, 1, 24'($urandom), 1'b0);
                1: apply_settings($urandom_range(1, 64), $urandom_range(1, 64),
                                  $urandom_range(2, 4), 24'($urandom), 1'b1);
                2: apply_settings(4096, 4096, 8, 24'hFFFFFF, 1'b1);
                3: apply_settings(1, 1, 1, 24'h000000, 1'b0);
                4: apply_settings($urandom_range(1, 8191), $urandom_range(1, 8191),
                                  $urandom_range(0, 15), 24'($urandom),
                                  1'($urandom));
                default: begin
                    idling_on = 1'b0;
                    apply_settings($urandom_range(64, 4096), $urandom_range(64, 4096),
                                   $urandom_range(1, 8), 24'($urandom),
                                   1'($urandom));
                end
            endcase
            repeat (ITEMS_PER_PHASE) queue_random_char();
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
